[src/box_ds_pkg.sv]
// Shared types and constants of the 2x2 box downsampler.
package box_ds_pkg;

  localparam int CFG_W          = 11;   // width of the configuration registers
  localparam int LINE_W         = 10;   // line counter width
  localparam int PIX_W          = 8;    // one color sample
  localparam int SUM_W          = PIX_W + 1;
  localparam int MAX_LINE_DEF   = 1024;
  localparam int LINE_COUNT_MAX = 1024;
  localparam int LINE_MIN       = 2;

  localparam logic [CFG_W-1:0] LINE_LENGTH_RST = CFG_W'(640);
  localparam logic [CFG_W-1:0] LINE_COUNT_RST  = CFG_W'(480);

  typedef enum logic [0:0] {
    CFG_LINE_LENGTH = 1'b0,
    CFG_LINE_COUNT  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } rgb_t;

  // Horizontal pair sums of the three channels, one line store entry.
  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
  } pair_sum_t;

endpackage

[src/box_ds_in_if.sv]
// Input pixel channel: valid/ready handshake with one RGB pixel.
interface box_ds_in_if import box_ds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

[src/box_ds_out_if.sv]
// Output pixel channel: valid/ready handshake with one averaged pixel.
interface box_ds_out_if import box_ds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;
  logic             frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

[src/box_downsample_2x2_top.sv]
// Path: a block's closing request loads stage 1, then the output register.
// Throughput: one pixel per cycle unless the output stalls; the line store takes
//   one write (even lines) or one read (odd lines) per pixel pair on one port.
// Reset (rst, synchronous): counters, held pixel and valid flags clear, registers
//   return to 640 x 480; the line store is not cleared, every odd line reads only
//   what the even line wrote.
module box_downsample_2x2_top import box_ds_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  box_ds_in_if.sink        in_px,
  box_ds_out_if.source     out_px
);

  localparam int DEPTH = MAX_LINE / 2;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W = IDX_W + 1;
  localparam int LEN_W = ($clog2(MAX_LINE + 1) > CFG_W) ? $clog2(MAX_LINE + 1) : CFG_W;

  logic [CFG_W-1:0] line_length;
  logic [CFG_W-1:0] line_count;
  logic [COL_W-1:0] col;
  logic [LINE_W-1:0] line;
  rgb_t             held;

  logic [LEN_W-1:0] len_raw, len_eff, len_even, col_ext;
  logic [CFG_W-1:0] cnt_eff, cnt_even, line_ext;
  logic             in_block, col_wrap, line_wrap, blk_end;
  logic             acc, pair_done, st_we, st_re;
  logic [IDX_W-1:0] idx;
  rgb_t             pix;
  pair_sum_t        pair;

  pair_sum_t        store [DEPTH];
  pair_sum_t        rdata;

  logic             s1_valid;
  pair_sum_t        s1_pair;
  logic             s1_end;
  logic             adv;
  logic [SUM_W:0]   tot_r, tot_g, tot_b;

  // Effective frame geometry, saturated into the legal range.
  always_comb begin
    len_raw = LEN_W'(line_length);
    if (len_raw < LEN_W'(LINE_MIN)) begin
      len_eff = LEN_W'(LINE_MIN);
    end else if (len_raw > LEN_W'(MAX_LINE)) begin
      len_eff = LEN_W'(MAX_LINE);
    end else begin
      len_eff = len_raw;
    end
    if (line_count < CFG_W'(LINE_MIN)) begin
      cnt_eff = CFG_W'(LINE_MIN);
    end else if (line_count > CFG_W'(LINE_COUNT_MAX)) begin
      cnt_eff = CFG_W'(LINE_COUNT_MAX);
    end else begin
      cnt_eff = line_count;
    end
    len_even = {len_eff[LEN_W-1:1], 1'b0};
    cnt_even = {cnt_eff[CFG_W-1:1], 1'b0};
  end

  assign col_ext   = LEN_W'(col);
  assign line_ext  = CFG_W'(line);
  assign in_block  = (col_ext < len_even) && (line_ext < cnt_even);
  assign col_wrap  = (col_ext + LEN_W'(1)) >= len_eff;
  assign line_wrap = (line_ext + CFG_W'(1)) >= cnt_eff;
  assign blk_end   = ((col_ext + LEN_W'(1)) == len_even) &&
                     ((line_ext + CFG_W'(1)) == cnt_even);

  assign pix  = '{r: in_px.red_in, g: in_px.green_in, b: in_px.blue_in};
  assign pair = '{r: SUM_W'(held.r) + SUM_W'(pix.r),
                  g: SUM_W'(held.g) + SUM_W'(pix.g),
                  b: SUM_W'(held.b) + SUM_W'(pix.b)};
  assign idx  = col[IDX_W:1];

  // Stage 1 moves on whenever the output register is free or being drained.
  assign adv          = !out_px.valid || out_px.ready;
  assign in_px.ready  = !rst && (!s1_valid || adv);
  assign acc          = in_px.valid && in_px.ready;
  assign pair_done    = acc && in_block && col[0];
  assign st_we        = pair_done && !line[0];
  assign st_re        = pair_done && line[0];

  // Configuration and frame position.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= LINE_LENGTH_RST;
      line_count  <= LINE_COUNT_RST;
      col         <= '0;
      line        <= '0;
      held        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_LENGTH: line_length <= cfg_data;
        CFG_LINE_COUNT:  line_count  <= cfg_data;
        default: ;
      endcase
      col  <= '0;
      line <= '0;
      held <= '0;
    end else if (acc) begin
      if (in_block && !col[0]) begin
        held <= pix;
      end
      if (col_wrap) begin
        col  <= '0;
        line <= line_wrap ? '0 : line + LINE_W'(1);
      end else begin
        col  <= col + COL_W'(1);
      end
    end
  end

  // Line store: even lines write pair sums, the next odd line reads them back.
  // Read and write of one entry are a full line apart, so no forwarding.
  always_ff @(posedge clk) begin
    if (st_we) begin
      store[idx] <= pair;
    end
  end

  always_ff @(posedge clk) begin
    if (st_re) begin
      rdata <= store[idx];
    end
  end

  // Stage 1: lower pair sum waits for the store read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (st_re) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_re) begin
      s1_pair <= pair;
      s1_end  <= blk_end;
    end
  end

  assign tot_r = (SUM_W+1)'(s1_pair.r) + (SUM_W+1)'(rdata.r);
  assign tot_g = (SUM_W+1)'(s1_pair.g) + (SUM_W+1)'(rdata.g);
  assign tot_b = (SUM_W+1)'(s1_pair.b) + (SUM_W+1)'(rdata.b);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_px.valid <= 1'b0;
    end else if (adv) begin
      out_px.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      out_px.red_out   <= tot_r[SUM_W:2];
      out_px.green_out <= tot_g[SUM_W:2];
      out_px.blue_out  <= tot_b[SUM_W:2];
      out_px.frame_end <= s1_end;
    end
  end

endmodule

[src/box_ds_chk.sv]
// Port-level checks of the 2x2 box downsampler, bound to the top level.
module box_ds_chk import box_ds_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] red_out,
  input logic [PIX_W-1:0] green_out,
  input logic [PIX_W-1:0] blue_out,
  input logic             frame_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(red_out) && $stable(green_out) &&
                                $stable(blue_out) && $stable(frame_end))
    else $error("stalled result changed");

  // No request taken while in reset; the output register is empty right after.
  a_rst_clear: assert property (@(posedge clk)
    rst |-> !in_ready ##1 !out_valid)
    else $error("reset did not clear the datapath");

  // A fresh result traces back to a taken request via stage 1 and the output.
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching request");

endmodule

bind box_downsample_2x2_top box_ds_chk u_box_ds_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_px.valid),
  .in_ready  (in_px.ready),
  .out_valid (out_px.valid),
  .out_ready (out_px.ready),
  .red_out   (out_px.red_out),
  .green_out (out_px.green_out),
  .blue_out  (out_px.blue_out),
  .frame_end (out_px.frame_end)
);
